### sv/fpmu_pkg.sv
`default_nettype none
package fpmu_pkg;

  localparam int SqrtCells = 16;
  localparam int DivCells = 48;

  localparam logic [2:0] OP_MUL = 3'd0;
  localparam logic [2:0] OP_DIV = 3'd1;
  localparam logic [2:0] OP_SQRT = 3'd2;
  localparam logic [2:0] OP_ISQRT = 3'd3;
  localparam logic [2:0] OP_SIN = 3'd4;
  localparam logic [2:0] OP_COS = 3'd5;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic signed [31:0] ROUND_HALF = 32'sd32;
  localparam logic [47:0] ONE_OVER_ROOT_DVD = 48'h0001_0000_0000;

  typedef struct packed {
    logic [2:0] op;
    logic err;
    logic use_div;
    logic neg;
    logic [31:0] res;
    logic [31:0] sq_rad;
    logic [17:0] sq_rem;
    logic [15:0] sq_root;
    logic [31:0] dv_rem;
    logic [47:0] dv_dvd;
    logic [31:0] dv_dsr;
  } fpmu_item_t;

  function automatic logic [14:0] quarter_wave(input logic [6:0] h);
    logic [14:0] v;
    case (h)
      7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd803;    7'd3: v = 15'd1205;
      7'd4: v = 15'd1605;   7'd5: v = 15'd2005;   7'd6: v = 15'd2404;   7'd7: v = 15'd2801;
      7'd8: v = 15'd3196;   7'd9: v = 15'd3589;   7'd10: v = 15'd3980;  7'd11: v = 15'd4369;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5519;  7'd15: v = 15'd5896;
      7'd16: v = 15'd6269;  7'd17: v = 15'd6639;  7'd18: v = 15'd7005;  7'd19: v = 15'd7366;
      7'd20: v = 15'd7723;  7'd21: v = 15'd8075;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9759;  7'd27: v = 15'd10079;
      7'd28: v = 15'd10393; 7'd29: v = 15'd10701; 7'd30: v = 15'd11002; 7'd31: v = 15'd11297;
      7'd32: v = 15'd11585; 7'd33: v = 15'd11866; 7'd34: v = 15'd12139; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13159; 7'd39: v = 15'd13395;
      7'd40: v = 15'd13622; 7'd41: v = 15'd13842; 7'd42: v = 15'd14053; 7'd43: v = 15'd14255;
      7'd44: v = 15'd14449; 7'd45: v = 15'd14634; 7'd46: v = 15'd14810; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15136; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426; 7'd51: v = 15'd15557;
      7'd52: v = 15'd15678; 7'd53: v = 15'd15790; 7'd54: v = 15'd15892; 7'd55: v = 15'd15985;
      7'd56: v = 15'd16069; 7'd57: v = 15'd16142; 7'd58: v = 15'd16206; 7'd59: v = 15'd16260;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16339; 7'd62: v = 15'd16364; 7'd63: v = 15'd16379;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] wave_at(input logic [7:0] s);
    logic [6:0] h;
    logic signed [31:0] v;
    h = s[6:0];
    if (h > 7'd64) h = 7'd0 - h;
    v = signed'({17'd0, quarter_wave(h)});
    return s[7] ? -v : v;
  endfunction

  function automatic logic [31:0] sine_of(input logic [15:0] ang);
    logic [7:0] step;
    logic signed [31:0] w1;
    logic signed [31:0] w0;
    logic signed [31:0] sum;
    step = ang[15:8];
    w1 = signed'({24'd0, ang[7:0]});
    w0 = 32'sd256 - w1;
    sum = wave_at(step) * w0 + wave_at(step + 8'd1) * w1 + ROUND_HALF;
    return unsigned'(sum >>> 6);
  endfunction

  function automatic fpmu_item_t div_setup(input fpmu_item_t it);
    fpmu_item_t o;
    o = it;
    if (!it.err && it.op == OP_SQRT) o.res = {8'd0, it.sq_root, 8'd0};
    if (it.use_div && it.op == OP_ISQRT) begin
      o.dv_dsr = (it.sq_root == 16'd0) ? 32'd1 : {8'd0, it.sq_root, 8'd0};
      o.dv_dvd = ONE_OVER_ROOT_DVD;
      o.dv_rem = 32'd0;
      o.neg = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [31:0] final_result(input fpmu_item_t it);
    if (!it.use_div) return it.res;
    return it.neg ? 32'd0 - it.dv_dvd[31:0] : it.dv_dvd[31:0];
  endfunction

endpackage
`default_nettype wire

### sv/fixed_point_math_unit.sv
`default_nettype none
// Signed 16.16 fixed-point unit: multiply, divide, square root, inverse root, sine, cosine.
// A beat is accepted every cycle unless a full pipeline is stalled; each operation uses a
// chain of one front stage, 16 root-digit cells and 48 restoring-division cells, each
// one register deep. A stalled output holds its beat while empty stages further up keep
// accepting. Divide by zero and a negative root input give result 0 with error set.
module fixed_point_math_unit
  import fpmu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] operation,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] result,
  output logic error
);

  logic sq_valid [SqrtCells+1];
  logic sq_ready [SqrtCells+1];
  fpmu_item_t sq_item [SqrtCells+1];
  logic dv_valid [DivCells+1];
  logic dv_ready [DivCells+1];
  fpmu_item_t dv_item [DivCells+1];

  fpmu_front_cell u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(sq_valid[0]), .out_ready(sq_ready[0]), .out_item(sq_item[0])
  );

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    fpmu_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(sq_valid[i]), .in_ready(sq_ready[i]), .in_item(sq_item[i]),
      .out_valid(sq_valid[i+1]), .out_ready(sq_ready[i+1]), .out_item(sq_item[i+1])
    );
  end

  assign dv_valid[0] = sq_valid[SqrtCells];
  assign sq_ready[SqrtCells] = dv_ready[0];
  assign dv_item[0] = div_setup(sq_item[SqrtCells]);

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    fpmu_div_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(dv_valid[i]), .in_ready(dv_ready[i]), .in_item(dv_item[i]),
      .out_valid(dv_valid[i+1]), .out_ready(dv_ready[i+1]), .out_item(dv_item[i+1])
    );
  end

  assign out_valid = dv_valid[DivCells];
  assign dv_ready[DivCells] = out_ready;
  assign result = final_result(dv_item[DivCells]);
  assign error = dv_item[DivCells].err;

endmodule
`default_nettype wire

### sv/fpmu_front_cell.sv
`default_nettype none
module fpmu_front_cell
  import fpmu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] operation,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic out_valid,
  input  wire logic out_ready,
  output fpmu_item_t out_item
);

  fpmu_item_t item_next;
  logic signed [63:0] prod;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [15:0] ang;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod = 64'(operand_a) * 64'(operand_b);
    mag_a = operand_a[31] ? 32'd0 - operand_a : operand_a;
    mag_b = operand_b[31] ? 32'd0 - operand_b : operand_b;
    ang = operand_a[15:0] + ((operation == OP_COS) ? QUARTER_TURN : 16'd0);
    item_next = '0;
    item_next.op = operation;
    case (operation)
      OP_MUL: item_next.res = prod[47:16];
      OP_DIV: begin
        if (operand_b == 32'sd0) begin
          item_next.err = 1'b1;
        end else begin
          item_next.use_div = 1'b1;
          item_next.neg = operand_a[31] ^ operand_b[31];
          item_next.dv_dvd = {mag_a, 16'd0};
          item_next.dv_dsr = mag_b;
        end
      end
      OP_SQRT, OP_ISQRT: begin
        if (operand_a[31]) begin
          item_next.err = 1'b1;
        end else begin
          item_next.sq_rad = operand_a;
          item_next.use_div = (operation == OP_ISQRT);
        end
      end
      OP_SIN, OP_COS: item_next.res = sine_of(ang);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_item <= item_next;
  end

endmodule
`default_nettype wire

### sv/fpmu_sqrt_cell.sv
`default_nettype none
module fpmu_sqrt_cell
  import fpmu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire fpmu_item_t in_item,
  output logic out_valid,
  input  wire logic out_ready,
  output fpmu_item_t out_item
);

  fpmu_item_t item_next;
  logic [17:0] rem_sh;
  logic [17:0] trial;
  logic fits;

  assign in_ready = !out_valid || out_ready;

  // one root digit per cell
  always_comb begin
    rem_sh = {in_item.sq_rem[15:0], in_item.sq_rad[31:30]};
    trial = {in_item.sq_root, 2'b01};
    fits = rem_sh >= trial;
    item_next = in_item;
    item_next.sq_rad = {in_item.sq_rad[29:0], 2'b00};
    item_next.sq_rem = fits ? rem_sh - trial : rem_sh;
    item_next.sq_root = {in_item.sq_root[14:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_item <= item_next;
  end

endmodule
`default_nettype wire

### sv/fpmu_div_cell.sv
`default_nettype none
module fpmu_div_cell
  import fpmu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire fpmu_item_t in_item,
  output logic out_valid,
  input  wire logic out_ready,
  output fpmu_item_t out_item
);

  fpmu_item_t item_next;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic fits;

  assign in_ready = !out_valid || out_ready;

  // one restoring quotient bit per cell
  always_comb begin
    rem_sh = {in_item.dv_rem, in_item.dv_dvd[47]};
    diff = rem_sh - {1'b0, in_item.dv_dsr};
    fits = rem_sh >= {1'b0, in_item.dv_dsr};
    item_next = in_item;
    item_next.dv_rem = fits ? diff[31:0] : rem_sh[31:0];
    item_next.dv_dvd = {in_item.dv_dvd[46:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_item <= item_next;
  end

endmodule
`default_nettype wire

### sv/fpmu_checker.sv
`default_nettype none
module fpmu_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] result,
  input wire logic error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(error))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> result == 32'd0)
    else $error("error beat with nonzero result");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fixed_point_math_unit fpmu_checker u_fpmu_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .result(result), .error(error)
);
`default_nettype wire
